### hw/rtl/tcw_pkg.sv
// Text console writer: shared types, codes, constants and the microcode ROM.
// Used by tcw_seq and text_console_writer_top; depends on nothing else.
`timescale 1ns / 1ps

package tcw_pkg;

  // Default geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Cell layout: attribute in the high byte, character in the low byte
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int POS_W  = 11;

  localparam logic [CHAR_W-1:0] BLANK_CHAR        = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR      = 8'h0a;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR_RESET = 8'h05;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET   = 8'h0f;

  // Request kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR   = 1'b1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAR_W-1:0] character;
    logic [6:0]        column;
    logic [4:0]        row;
    logic [ATTR_W-1:0] attribute;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_position;
    logic [CHAR_W-1:0] cell_character;
    logic [ATTR_W-1:0] cell_attribute;
    logic              scrolled;
  } rsp_t;

  // Microprogram steps
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_SCR_RD,
    S_SCR_WR,
    S_FILL,
    S_RD_ADDR,
    S_RD_DATA,
    S_EMIT
  } step_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_RD_TARGET,
    MEM_RD_SHIFT,
    MEM_WR_PUT,
    MEM_WR_COPY,
    MEM_WR_BLANK,
    MEM_WR_INIT
  } mem_op_t;

  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_INC,
    PTR_ZERO
  } ptr_op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_DISPATCH,
    BR_WRAP,
    BR_COPY,
    BR_FILL
  } br_t;

  // One control word per step
  typedef struct packed {
    mem_op_t mem_op;
    ptr_op_t ptr_op;
    logic    emit;
    logic    cell_sel;
    br_t     br;
    step_t   target;
    step_t   next;
  } ctrl_t;

  // Conditions from the datapath for branching
  typedef struct packed {
    logic       go;
    logic [1:0] kind;
    logic       wrap;
    logic       copy_end;
    logic       fill_end;
  } cond_t;

  // Microcode ROM
  function automatic ctrl_t rom(input step_t s);
    ctrl_t w;
    w = '{MEM_NONE, PTR_ZERO, 1'b0, 1'b0, BR_DISPATCH, S_IDLE, S_IDLE};
    case (s)
      S_INIT:    w = '{MEM_WR_INIT,   PTR_INC,  1'b0, 1'b0, BR_FILL,     S_IDLE,   S_INIT};
      S_IDLE:    w = '{MEM_NONE,      PTR_ZERO, 1'b0, 1'b0, BR_DISPATCH, S_IDLE,   S_IDLE};
      S_PUT:     w = '{MEM_WR_PUT,    PTR_ZERO, 1'b1, 1'b0, BR_WRAP,     S_SCR_RD, S_IDLE};
      S_SCR_RD:  w = '{MEM_RD_SHIFT,  PTR_HOLD, 1'b0, 1'b0, BR_NEXT,     S_SCR_WR, S_SCR_WR};
      S_SCR_WR:  w = '{MEM_WR_COPY,   PTR_INC,  1'b0, 1'b0, BR_COPY,     S_FILL,   S_SCR_RD};
      S_FILL:    w = '{MEM_WR_BLANK,  PTR_INC,  1'b0, 1'b0, BR_FILL,     S_EMIT,   S_FILL};
      S_RD_ADDR: w = '{MEM_RD_TARGET, PTR_HOLD, 1'b0, 1'b0, BR_NEXT,     S_RD_DATA, S_RD_DATA};
      S_RD_DATA: w = '{MEM_NONE,      PTR_HOLD, 1'b1, 1'b1, BR_NEXT,     S_IDLE,   S_IDLE};
      S_EMIT:    w = '{MEM_NONE,      PTR_HOLD, 1'b1, 1'b0, BR_NEXT,     S_IDLE,   S_IDLE};
      default:   w = '{MEM_NONE,      PTR_ZERO, 1'b0, 1'b0, BR_DISPATCH, S_IDLE,   S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/text_console_writer_top.sv
// Text console writer: cursor and request datapath, cell store, result register.
// Depends on tcw_pkg, tcw_ram and tcw_seq.
`timescale 1ns / 1ps
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------
//  cmd      | cmd_valid, cmd_ready, cmd        | one request (put/clear/read)
//  rsp      | rsp_valid, rsp_ready, rsp        | one result per request
//  cfg      | cfg_we, cfg_index, cfg_data      | register write, no handshake
//
//  Put: accept, then cell write and result. Read: accept, address, then data and result.
//  Put that scrolls: accept and cell write, a two-step copy per moved cell through
//  the single RAM read port, one blank per bottom-row cell, then the result.
//  Clear: accept, one blank written per cycle over all ROWS*COLUMNS cells, then the result.
//  After reset a clearing pass over all ROWS*COLUMNS cells runs before cmd_ready rises.
//  A held result stalls the sequencer only at the step that issues the next one.

module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  tcw_pkg::cmd_t                       cmd,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output tcw_pkg::rsp_t                       rsp,
  input  logic                                cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcw_pkg::ATTR_W-1:0]          cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;
  localparam int MOVED = (ROWS - 1) * COLUMNS;
  localparam int LAST  = CELLS - 1;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  ctrl_t cw;
  cond_t cond;

  cmd_t              req;
  logic [ATTR_W-1:0] default_attribute;
  logic [ATTR_W-1:0] blank_attribute;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row_next;
  logic [CW-1:0]     cur_col_next;
  logic              scroll_flag;
  logic [AW-1:0]     ptr;

  logic              accept;
  logic              go;
  logic              emit_now;
  logic              in_range;
  logic [RW-1:0]     pos_row;
  logic [CW-1:0]     pos_col;
  logic [AW-1:0]     target_addr;
  logic              is_nl;
  logic [CW:0]       col_inc;
  logic              row_adv;
  logic [RW:0]       row_inc;
  logic              wrap;
  logic [ATTR_W-1:0] attr_eff;
  logic [AW-1:0]     cur_lin;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      default_attribute <= DEFAULT_ATTR_RESET;
      blank_attribute   <= BLANK_ATTR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT_ATTR: default_attribute <= cfg_data;
        REG_BLANK_ATTR:   blank_attribute   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Resolve the target cell and the advanced cursor for a put
  always_comb begin
    in_range    = (32'(req.column) < COLUMNS) && (32'(req.row) < ROWS);
    pos_row     = in_range ? req.row[RW-1:0] : cur_row;
    pos_col     = in_range ? req.column[CW-1:0] : cur_col;
    target_addr = AW'(pos_row) * AW'(COLUMNS) + AW'(pos_col);
    is_nl       = (req.character == NEWLINE_CHAR);
    col_inc     = {1'b0, pos_col} + (CW+1)'(1);
    row_adv     = is_nl || (col_inc == (CW+1)'(COLUMNS));
    row_inc     = {1'b0, pos_row} + (RW+1)'(row_adv);
    wrap        = row_adv && (row_inc == (RW+1)'(ROWS));
    attr_eff    = (req.attribute != '0) ? req.attribute : default_attribute;
  end

  // Handshake and stall
  assign cmd_ready = (cw.br == BR_DISPATCH);
  assign accept    = cmd_valid && cmd_ready;
  assign emit_now  = cw.emit && !((cw.br == BR_WRAP) && wrap);
  assign go        = !((cw.br == BR_DISPATCH) && !cmd_valid) &&
                     !(emit_now && rsp_valid && !rsp_ready);

  // Branch conditions for the sequencer
  always_comb begin
    cond.go       = go;
    cond.kind     = cmd.kind;
    cond.wrap     = wrap;
    cond.copy_end = (ptr == AW'(MOVED - 1));
    cond.fill_end = (ptr == AW'(LAST));
  end

  tcw_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .cw   (cw)
  );

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= cmd;
    end
  end

  // Next cursor: home on clear, advance or scroll on put
  always_comb begin
    cur_row_next = cur_row;
    cur_col_next = cur_col;
    if (accept && (cmd.kind == KIND_CLEAR)) begin
      cur_row_next = '0;
      cur_col_next = '0;
    end else if (go && (cw.mem_op == MEM_WR_PUT)) begin
      if (wrap) begin
        cur_row_next = RW'(ROWS - 1);
        cur_col_next = '0;
      end else begin
        cur_row_next = row_inc[RW-1:0];
        cur_col_next = row_adv ? '0 : col_inc[CW-1:0];
      end
    end
  end

  assign cur_lin = AW'(cur_row_next) * AW'(COLUMNS) + AW'(cur_col_next);

  // Cursor, scroll flag and sweep pointer; the pointer wraps after the last cell
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row     <= '0;
      cur_col     <= '0;
      scroll_flag <= 1'b0;
      ptr         <= '0;
    end else begin
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
      if (accept) begin
        scroll_flag <= 1'b0;
      end else if (go && (cw.mem_op == MEM_WR_PUT) && wrap) begin
        scroll_flag <= 1'b1;
      end
      if (go) begin
        case (cw.ptr_op)
          PTR_INC:  ptr <= (ptr == AW'(LAST)) ? '0 : ptr + AW'(1);
          PTR_ZERO: ptr <= '0;
          default:  ;
        endcase
      end
    end
  end

  // Decode the memory operation of this step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = {blank_attribute, BLANK_CHAR};
    ram_re    = 1'b0;
    ram_raddr = target_addr;
    case (cw.mem_op)
      MEM_RD_TARGET: ram_re = go;
      MEM_RD_SHIFT: begin
        ram_re    = go;
        ram_raddr = ptr + AW'(COLUMNS);
      end
      MEM_WR_PUT: begin
        ram_we    = go && !is_nl;
        ram_waddr = target_addr;
        ram_wdata = {attr_eff, req.character};
      end
      MEM_WR_COPY: begin
        ram_we    = go;
        ram_wdata = ram_rdata;
      end
      MEM_WR_BLANK: ram_we = go;
      MEM_WR_INIT: begin
        ram_we    = go;
        ram_wdata = {BLANK_ATTR_RESET, BLANK_CHAR};
      end
      default: ;
    endcase
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result register: load on issue, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (go && emit_now) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit_now) begin
      rsp.cursor_position <= POS_W'(cur_lin);
      rsp.cell_character  <= cw.cell_sel ? ram_rdata[CHAR_W-1:0] : '0;
      rsp.cell_attribute  <= cw.cell_sel ? ram_rdata[CELL_W-1:CHAR_W] : '0;
      rsp.scrolled        <= scroll_flag;
    end
  end

  // Cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_row) < ROWS) && (32'(cur_col) < COLUMNS))
    else $error("cursor outside screen");

  // Sweep pointer stays inside the store
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    32'(ptr) <= LAST)
    else $error("sweep pointer past last cell");

  // A scrolled result always leaves the cursor at the start of the bottom row
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.scrolled |-> rsp.cursor_position == POS_W'(MOVED))
    else $error("scroll result with wrong cursor");

  // No request is taken while the store is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (cw.mem_op == MEM_WR_BLANK || cw.mem_op == MEM_WR_COPY ||
     cw.mem_op == MEM_WR_INIT) |-> !cmd_ready)
    else $error("request port open during sweep");

endmodule

### hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/tcw_seq.sv
// Microcode sequencer: step register, control ROM lookup and branch logic.
// Depends on tcw_pkg for step codes, control word and condition types.
`timescale 1ns / 1ps

module tcw_seq (
  input  logic           clk,
  input  logic           rst,
  input  tcw_pkg::cond_t cond,
  output tcw_pkg::ctrl_t cw
);
  import tcw_pkg::*;

  step_t step;
  step_t step_next;

  // Step register; start with the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_INIT;
    end else begin
      step <= step_next;
    end
  end

  // Look up the control word and pick the next step
  always_comb begin
    cw        = rom(step);
    step_next = step;
    if (cond.go) begin
      case (cw.br)
        BR_NEXT:     step_next = cw.next;
        BR_DISPATCH: begin
          case (cond.kind)
            KIND_PUT:   step_next = S_PUT;
            KIND_CLEAR: step_next = S_FILL;
            KIND_READ:  step_next = S_RD_ADDR;
            default:    step_next = S_EMIT;
          endcase
        end
        BR_WRAP:     step_next = cond.wrap     ? cw.target : cw.next;
        BR_COPY:     step_next = cond.copy_end ? cw.target : cw.next;
        BR_FILL:     step_next = cond.fill_end ? cw.target : cw.next;
        default:     step_next = cw.next;
      endcase
    end
  end

endmodule
